FILE: rtl/rbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbb_pkg
// Shared types and codes for the rgb box blur filter.
// ----------------------------------------------------------------------------
package rbb_pkg;

  // one rgb pixel as held in the line store
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // input word operation codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  localparam int CFG_DATA_W = 12;

endpackage

FILE: rtl/rbb_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbb_in_if
// Input channel: pixel or flush word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rbb_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, output operation, output red_in, output green_in,
                  output blue_in, input ready);
  modport sink (input valid, input operation, input red_in, input green_in,
                input blue_in, output ready);
endinterface

FILE: rtl/rbb_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbb_out_if
// Output channel: blurred pixel word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rbb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_last;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output frame_last, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input frame_last, output ready);
endinterface

FILE: rtl/rbb_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbb_lane
// One line store row bank with registered read, gated to zero when the
// fetched pixel lies outside the window or the frame.
// ----------------------------------------------------------------------------
module rbb_lane #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  rbb_pkg::pixel_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  input  logic            rd_use,
  output rbb_pkg::pixel_t rd_data
);

  rbb_pkg::pixel_t mem [DEPTH];
  rbb_pkg::pixel_t rd_q;
  logic            use_q;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q  <= mem[rd_addr];
      use_q <= rd_use;
    end
  end

  assign rd_data = use_q ? rd_q : '0;

endmodule

FILE: rtl/rbb_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbb_div
// Rounded mean: (2*sum + count) / (2*count) for three channels side by
// side, restoring division one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rbb_div #(
  parameter int SW = 13,
  parameter int CW = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [2:0][SW-1:0]  sums,
  input  logic [CW-1:0]       count,
  output logic                busy,
  output rbb_pkg::pixel_t     result
);

  localparam int XW = SW + 10;

  logic [XW-1:0]       den;
  logic [2:0][XW-1:0]  rem;
  logic [2:0][7:0]     quo;
  logic [2:0]          step;
  logic [XW-1:0]       cand;

  assign cand = den << step;

  // one quotient bit per cycle, most significant first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      step <= 3'd7;
      den  <= XW'({count, 1'b0});
      for (int c = 0; c < 3; c++) begin
        rem[c] <= XW'({sums[c], 1'b0}) + XW'(count);
        quo[c] <= '0;
      end
    end else if (busy) begin
      for (int c = 0; c < 3; c++) begin
        if (rem[c] >= cand) begin
          rem[c]       <= rem[c] - cand;
          quo[c][step] <= 1'b1;
        end
      end
      if (step == 3'd0) begin
        busy <= 1'b0;
      end else begin
        step <= step - 3'd1;
      end
    end
  end

  assign result.red   = quo[0];
  assign result.green = quo[1];
  assign result.blue  = quo[2];

endmodule

FILE: rtl/rgb_box_blur_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_box_blur_filter
// Streaming box blur over rgb pixels in raster order, border aware mean.
// ----------------------------------------------------------------------------
// A word that yields no result leaves the filter idle and ready for the next
// word. A word that yields a result goes through a window fetch of
// 2*radius+1 columns (one column of all row banks per read/add pair), then
// division, then waits in the output register.
// Reset clears all position counters and loads 640, 480 and 1 into the
// registers; the line store is not cleared, every entry is written first.
module rgb_box_blur_filter #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int MAX_RADIUS = 2
) (
  input  logic                             clk,
  input  logic                             rst,
  rbb_in_if.sink                           in_ch,
  rbb_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [rbb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int WIN   = 2 * MAX_RADIUS + 1;
  localparam int SR    = 2 * MAX_RADIUS + 2;
  localparam int SRW   = $clog2(SR);
  localparam int CLW   = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int RADW  = $clog2(MAX_RADIUS + 1);
  localparam int JW    = $clog2(WIN);
  localparam int CW    = $clog2(WIN * WIN + 1);
  localparam int SW    = 8 + CW;
  localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int TW    = CLW + 6;
  localparam int XW    = RW + 6;
  localparam int W_RST = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam int H_RST = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_ACC, S_DIVGO, S_DIVWAIT, S_OUT} state_t;

  state_t            state;
  logic [WW-1:0]     w;
  logic [HW-1:0]     h;
  logic [RADW-1:0]   r;

  logic [CLW-1:0]    in_col;
  logic [RW-1:0]     in_row;
  logic [SRW-1:0]    in_rmod;
  logic              in_done;
  logic [CLW-1:0]    out_col;
  logic [RW-1:0]     out_row;
  logic [SRW-1:0]    out_rmod;
  logic [PW-1:0]     pending;

  logic [CLW-1:0]    cur_col;
  logic [RW-1:0]     cur_row;
  logic [SRW-1:0]    cur_rmod;
  logic              cur_last;
  logic [JW-1:0]     j;
  logic              colv_q;
  logic [2:0][SW-1:0] sums;
  logic [CW-1:0]     cnt;

  // decoded controls
  logic              accept;
  logic              px_wr;
  logic              in_last_px;
  logic              in_done_next;
  logic [PW-1:0]     pend_next;
  logic [PW-1:0]     lag;
  logic              emit;
  logic              out_last;
  logic [SRW:0]      start_mod;
  logic [SR-1:0]     row_en;
  logic [CW-1:0]     row_cnt;
  logic [TW-1:0]     col_t;
  logic              col_ok;
  logic [CLW-1:0]    rd_addr;
  logic              div_busy;
  rbb_pkg::pixel_t   div_res;
  rbb_pkg::pixel_t   wr_px;
  rbb_pkg::pixel_t   lane_data [SR];
  logic [2:0][SW-1:0] lane_sum;

  assign accept       = in_ch.valid && in_ch.ready;
  assign px_wr        = accept && (in_ch.operation == rbb_pkg::OP_PIXEL) && !in_done;
  assign in_last_px   = (WW'(in_col) == w - WW'(1)) && (HW'(in_row) == h - HW'(1));
  assign in_done_next = in_done || (px_wr && in_last_px);
  assign pend_next    = pending + PW'(px_wr);
  assign lag          = PW'(r) * PW'(w) + PW'(r);
  assign emit         = accept && (in_done_next || pend_next > lag);
  assign out_last     = (WW'(out_col) == w - WW'(1)) && (HW'(out_row) == h - HW'(1));

  assign wr_px.red   = in_ch.red_in;
  assign wr_px.green = in_ch.green_in;
  assign wr_px.blue  = in_ch.blue_in;

  // bank holding the top row of the window
  always_comb begin
    if ((SRW + 1)'(cur_rmod) >= (SRW + 1)'(r)) begin
      start_mod = (SRW + 1)'(cur_rmod) - (SRW + 1)'(r);
    end else begin
      start_mod = (SRW + 1)'(cur_rmod) + (SRW + 1)'(SR) - (SRW + 1)'(r);
    end
  end

  // per bank: is its row inside the window and the frame
  for (genvar b = 0; b < SR; b++) begin : g_row
    logic [SRW:0] d;
    logic [XW-1:0] rr;
    always_comb begin
      if ((SRW + 1)'(b) >= start_mod) begin
        d = (SRW + 1)'(b) - start_mod;
      end else begin
        d = (SRW + 1)'(b) + (SRW + 1)'(SR) - start_mod;
      end
      rr = XW'(cur_row) + XW'(d);
      row_en[b] = (XW'(d) <= XW'(2) * XW'(r)) && (rr >= XW'(r)) && (rr < XW'(h) + XW'(r));
    end
  end

  assign row_cnt = CW'($countones(row_en));

  // column of the current fetch
  assign col_t   = TW'(cur_col) + TW'(j);
  assign col_ok  = (col_t >= TW'(r)) && (col_t < TW'(w) + TW'(r));
  assign rd_addr = CLW'(col_t - TW'(r));

  // row bank lanes
  for (genvar b = 0; b < SR; b++) begin : g_lane
    rbb_lane #(.DEPTH(MAX_WIDTH), .AW(CLW)) u_lane (
      .clk     (clk),
      .wr_en   (px_wr && (in_rmod == SRW'(b))),
      .wr_addr (in_col),
      .wr_data (wr_px),
      .rd_en   (state == S_RD),
      .rd_addr (rd_addr),
      .rd_use  (row_en[b] && col_ok),
      .rd_data (lane_data[b])
    );
  end

  // merge the lanes of one column
  always_comb begin
    lane_sum = '0;
    for (int b = 0; b < SR; b++) begin
      lane_sum[0] = lane_sum[0] + SW'(lane_data[b].red);
      lane_sum[1] = lane_sum[1] + SW'(lane_data[b].green);
      lane_sum[2] = lane_sum[2] + SW'(lane_data[b].blue);
    end
  end

  rbb_div #(.SW(SW), .CW(CW)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (state == S_DIVGO),
    .sums   (sums),
    .count  (cnt),
    .busy   (div_busy),
    .result (div_res)
  );

  assign in_ch.ready       = (state == S_IDLE);
  assign out_ch.valid      = (state == S_OUT);
  assign out_ch.red_out    = div_res.red;
  assign out_ch.green_out  = div_res.green;
  assign out_ch.blue_out   = div_res.blue;
  assign out_ch.frame_last = cur_last;

  // control, positions and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      w        <= WW'(W_RST);
      h        <= HW'(H_RST);
      r        <= RADW'(1);
      in_col   <= '0;
      in_row   <= '0;
      in_rmod  <= '0;
      in_done  <= 1'b0;
      out_col  <= '0;
      out_row  <= '0;
      out_rmod <= '0;
      pending  <= '0;
      cur_last <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == rbb_pkg::REG_WIDTH || cfg_index == rbb_pkg::REG_HEIGHT ||
                     cfg_index == rbb_pkg::REG_RADIUS)) begin
        unique case (cfg_index)
          rbb_pkg::REG_WIDTH: begin
            if (cfg_data == '0) w <= WW'(1);
            else if (int'(cfg_data) > MAX_WIDTH) w <= WW'(MAX_WIDTH);
            else w <= WW'(cfg_data);
          end
          rbb_pkg::REG_HEIGHT: begin
            if (cfg_data == '0) h <= HW'(1);
            else if (int'(cfg_data) > MAX_HEIGHT) h <= HW'(MAX_HEIGHT);
            else h <= HW'(cfg_data);
          end
          default: begin
            if (int'(cfg_data[1:0]) > MAX_RADIUS) r <= RADW'(MAX_RADIUS);
            else r <= RADW'(cfg_data[1:0]);
          end
        endcase
        in_col   <= '0;
        in_row   <= '0;
        in_rmod  <= '0;
        in_done  <= 1'b0;
        out_col  <= '0;
        out_row  <= '0;
        out_rmod <= '0;
        pending  <= '0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            // store the pixel and advance the input position
            if (px_wr) begin
              if (WW'(in_col) == w - WW'(1)) begin
                in_col  <= '0;
                in_row  <= in_row + RW'(1);
                in_rmod <= (in_rmod == SRW'(SR - 1)) ? '0 : in_rmod + SRW'(1);
              end else begin
                in_col <= in_col + CLW'(1);
              end
            end
            in_done <= in_done_next;
            pending <= pend_next;
            if (emit) begin
              cur_col  <= out_col;
              cur_row  <= out_row;
              cur_rmod <= out_rmod;
              cur_last <= out_last;
              pending  <= pend_next - PW'(1);
              j        <= '0;
              sums     <= '0;
              cnt      <= '0;
              state    <= S_RD;
              if (WW'(out_col) == w - WW'(1)) begin
                out_col  <= '0;
                out_row  <= out_row + RW'(1);
                out_rmod <= (out_rmod == SRW'(SR - 1)) ? '0 : out_rmod + SRW'(1);
              end else begin
                out_col <= out_col + CLW'(1);
              end
              // final output of the frame: start over
              if (out_last) begin
                in_col   <= '0;
                in_row   <= '0;
                in_rmod  <= '0;
                in_done  <= 1'b0;
                out_col  <= '0;
                out_row  <= '0;
                out_rmod <= '0;
                pending  <= '0;
              end
            end
          end
        end
        S_RD: begin
          colv_q <= col_ok;
          state  <= S_ACC;
        end
        S_ACC: begin
          for (int c = 0; c < 3; c++) begin
            sums[c] <= sums[c] + lane_sum[c];
          end
          cnt <= cnt + (colv_q ? row_cnt : CW'(0));
          if (JW'(j) == JW'(2) * JW'(r)) begin
            state <= S_DIVGO;
          end else begin
            j     <= j + JW'(1);
            state <= S_RD;
          end
        end
        S_DIVGO: begin
          state <= S_DIVWAIT;
        end
        S_DIVWAIT: begin
          if (!div_busy) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the window always holds the center pixel
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIVGO |-> cnt != '0)
    else $error("window count is zero at division start");

  // input and output never open at the same time
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while a word waits at the output");

  // outputs never fall further behind than the window lag
  a_lag_bound: assert property (@(posedge clk) disable iff (rst)
    !in_done |-> pending <= lag)
    else $error("pending outputs exceed window lag");

  // division result settles before it is offered
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !div_busy)
    else $error("output offered while division runs");

endmodule
